@@ src/two_axle_steering_odometry_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the two-axle steering odometry block
// Concurrent checks; empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef TWO_AXLE_STEERING_ODOMETRY_ASSERT_SVH
`define TWO_AXLE_STEERING_ODOMETRY_ASSERT_SVH
`ifndef SYNTH
`define TASO_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TASO_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TASO_ASSERT(name, clk, rst, prop, msg)
`define TASO_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

@@ src/taso_pkg.sv @@
// ---------------------------------------------------------------------------
// taso_pkg
// Shared types and constants of the two-axle steering odometry block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package taso_pkg;

  localparam int SPEED_W   = 16;
  localparam int ANGLE_W   = 16;
  localparam int LEN_W     = 13;
  localparam int HUB_W     = 11;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 3;

  localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 16'sd22938;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRONT_WHEELBASE = 3'd0,
    CFG_REAR_WHEELBASE  = 3'd1,
    CFG_FRONT_TRACK     = 3'd2,
    CFG_REAR_TRACK      = 3'd3,
    CFG_FRONT_HUB       = 3'd4,
    CFG_REAR_HUB        = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0] fl;
    logic signed [SPEED_W-1:0] fr;
    logic signed [SPEED_W-1:0] rl;
    logic signed [SPEED_W-1:0] rr;
    logic signed [ANGLE_W-1:0] fa;
    logic signed [ANGLE_W-1:0] ra;
  } frame_t;

  // atan(2^-i) in Q30, truncated
  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

endpackage

`default_nettype wire

@@ src/two_axle_steering_odometry.sv @@
// ---------------------------------------------------------------------------
// two_axle_steering_odometry
// Four-wheel, two-axle steering odometry: wheel speeds and axle angles in,
// corrected longitudinal speed out.
// ---------------------------------------------------------------------------
// One frame enters per clock while the pipeline advances; the depth comes
// from the tangent CORDIC, the bit-per-stage dividers for tangent,
// curvature and wheel speed, and the bit-per-stage root. The pipeline only
// halts while a result waits on a stalled output. The user must hold the
// geometry registers static while frames are in flight; the block itself
// does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module two_axle_steering_odometry #(
  parameter int FRAC_BITS  = 14,
  parameter int ITERATIONS = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_write,
  input  wire logic [taso_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [taso_pkg::CFG_W-1:0]            cfg_data,
  input  wire logic                                  frame_valid,
  output logic                                       frame_stall,
  input  wire logic signed [taso_pkg::SPEED_W-1:0]   front_left_speed,
  input  wire logic signed [taso_pkg::SPEED_W-1:0]   front_right_speed,
  input  wire logic signed [taso_pkg::SPEED_W-1:0]   rear_left_speed,
  input  wire logic signed [taso_pkg::SPEED_W-1:0]   rear_right_speed,
  input  wire logic signed [taso_pkg::ANGLE_W-1:0]   front_angle,
  input  wire logic signed [taso_pkg::ANGLE_W-1:0]   rear_angle,
  output logic                                       result_valid,
  input  wire logic                                  result_stall,
  output logic signed [taso_pkg::SPEED_W-1:0]        longitudinal_speed,
  output logic signed [taso_pkg::ANGLE_W-1:0]        front_angle_out,
  output logic signed [taso_pkg::ANGLE_W-1:0]        rear_angle_out,
  output logic                                       geometry_fault
);

  `include "two_axle_steering_odometry_assert.svh"

  localparam int F      = FRAC_BITS;
  localparam int TW     = F + 5;
  localparam int DTW    = F + 6;
  localparam int PW     = F + 20;
  localparam int CW     = F + 8;
  localparam int AW     = F + 9;
  localparam int SW     = 2 * F + 20;
  localparam int H      = F + 10;
  localparam int GW     = F + 12;
  localparam int GDW    = F + 11;
  localparam int QW     = F + 24;
  localparam int SUMW   = F + 26;
  localparam int LW     = taso_pkg::LEN_W + 1;
  localparam int FRW    = $bits(taso_pkg::frame_t);
  localparam int LAT_TAN  = 1 + ITERATIONS + (2 * F + 3) + 2;
  localparam int LAT_CURV = PW + 2;
  localparam int LAT_QUO  = QW + 2;

  localparam logic signed [PW-1:0] TERM = PW'(64) << F;
  localparam logic signed [AW-1:0] ONE  = AW'(1) << F;

  // ---------------- configuration ----------------
  logic [taso_pkg::LEN_W-1:0] front_wheelbase_mm, rear_wheelbase_mm;
  logic [taso_pkg::LEN_W-1:0] front_track_mm, rear_track_mm;
  logic [taso_pkg::HUB_W-1:0] front_hub_offset_mm, rear_hub_offset_mm;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_wheelbase_mm  <= 13'd1000;
      rear_wheelbase_mm   <= 13'd1000;
      front_track_mm      <= 13'd1000;
      rear_track_mm       <= 13'd1000;
      front_hub_offset_mm <= '0;
      rear_hub_offset_mm  <= '0;
    end else if (cfg_write) begin
      case (taso_pkg::cfg_reg_t'(cfg_index))
        taso_pkg::CFG_FRONT_WHEELBASE: front_wheelbase_mm  <= cfg_data;
        taso_pkg::CFG_REAR_WHEELBASE:  rear_wheelbase_mm   <= cfg_data;
        taso_pkg::CFG_FRONT_TRACK:     front_track_mm      <= cfg_data;
        taso_pkg::CFG_REAR_TRACK:      rear_track_mm       <= cfg_data;
        taso_pkg::CFG_FRONT_HUB:       front_hub_offset_mm <= cfg_data[taso_pkg::HUB_W-1:0];
        taso_pkg::CFG_REAR_HUB:        rear_hub_offset_mm  <= cfg_data[taso_pkg::HUB_W-1:0];
        default: ;
      endcase
    end
  end

  logic [LW-1:0] len;
  logic          len_zero;
  assign len      = LW'(front_wheelbase_mm) + LW'(rear_wheelbase_mm);
  assign len_zero = (len == '0);

  // whole pipeline advances unless a finished result is held
  logic adv;
  assign adv         = !(result_valid && result_stall);
  assign frame_stall = !adv;

  taso_pkg::frame_t frm;
  assign frm = '{fl: front_left_speed, fr: front_right_speed, rl: rear_left_speed,
                 rr: rear_right_speed, fa: front_angle, ra: rear_angle};

  // ---------------- tangents ----------------
  logic signed [TW-1:0] tan_f, tan_r;
  logic                 v_t;
  taso_pkg::frame_t     side_t;

  taso_tan #(.FRAC_BITS(F), .ITERATIONS(ITERATIONS)) u_tan_f (
    .clk(clk), .en(adv), .angle(front_angle), .tan_q(tan_f));
  taso_tan #(.FRAC_BITS(F), .ITERATIONS(ITERATIONS)) u_tan_r (
    .clk(clk), .en(adv), .angle(rear_angle), .tan_q(tan_r));
  taso_delay #(.W(FRW), .DEPTH(LAT_TAN)) u_dly_tan (
    .clk(clk), .rst(rst), .en(adv), .vin(frame_valid), .din(frm),
    .vout(v_t), .dout(side_t));

  // ---------------- tangent difference and products ----------------
  logic                 v_d, v_p;
  logic signed [DTW-1:0] d_q;
  logic signed [TW-1:0] tf_d, tr_d, tf_p, tr_p;
  taso_pkg::frame_t     side_d, side_p;
  logic signed [PW-1:0] prod [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_d <= 1'b0;
      v_p <= 1'b0;
    end else if (adv) begin
      v_d <= v_t;
      v_p <= v_d;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_q     <= DTW'(tan_f) - DTW'(tan_r);
      tf_d    <= tan_f;
      tr_d    <= tan_r;
      side_d  <= side_t;
      prod[0] <= PW'(d_q) * PW'($signed({1'b0, front_track_mm}));
      prod[1] <= PW'(d_q) * PW'($signed({1'b0, rear_track_mm}));
      prod[2] <= PW'(d_q) * PW'($signed({1'b0, front_hub_offset_mm}));
      prod[3] <= PW'(d_q) * PW'($signed({1'b0, rear_hub_offset_mm}));
      tf_p    <= tf_d;
      tr_p    <= tr_d;
      side_p  <= side_d;
    end
  end

  // ---------------- curvature terms ----------------
  // half-track terms divide by 2L, hub terms by L
  logic [LW:0]          den_half, den_hub;
  logic signed [PW-1:0] cq [4];
  assign den_half = {len, 1'b0};
  assign den_hub  = {1'b0, len};

  for (genvar k = 0; k < 4; k++) begin : g_curv
    taso_div #(.NW(PW), .DW(LW + 1)) u_div (
      .clk(clk), .en(adv), .num(prod[k]),
      .den((k < 2) ? den_half : den_hub), .quo(cq[k]));
  end

  logic                 v_cd;
  logic [FRW+2*TW-1:0]  side_cd;
  taso_delay #(.W(FRW + 2 * TW), .DEPTH(LAT_CURV)) u_dly_curv (
    .clk(clk), .rst(rst), .en(adv), .vin(v_p), .din({side_p, tf_p, tr_p}),
    .vout(v_cd), .dout(side_cd));

  // ---------------- clamp ----------------
  logic signed [CW-1:0] cc_next [4];
  logic [3:0]           csat;
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      csat[k] = 1'b0;
      if (cq[k] > TERM) begin
        cc_next[k] = CW'(TERM);
        csat[k]    = 1'b1;
      end else if (cq[k] < -TERM) begin
        cc_next[k] = CW'(-TERM);
        csat[k]    = 1'b1;
      end else begin
        cc_next[k] = cq[k][CW-1:0];
      end
    end
  end

  logic                 v_c, v_q, v_r;
  logic signed [CW-1:0] cc [4];
  logic                 fault_c, fault_q, fault_r;
  taso_pkg::frame_t     side_c, side_q, side_r;
  logic signed [TW-1:0] tf_c, tr_c;
  logic [SW-1:0]        asq [4];
  logic [SW-1:0]        tsq_f, tsq_r;
  logic signed [CW-1:0] hf_q, hr_q, hf_r, hr_r;
  logic [SW-1:0]        rad [4];
  logic signed [AW-1:0] alpha [4];

  always_comb begin
    alpha[0] = ONE - AW'(cc[0]);
    alpha[1] = ONE + AW'(cc[0]);
    alpha[2] = ONE - AW'(cc[1]);
    alpha[3] = ONE + AW'(cc[1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_c <= 1'b0;
      v_q <= 1'b0;
      v_r <= 1'b0;
    end else if (adv) begin
      v_c <= v_cd;
      v_q <= v_c;
      v_r <= v_q;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cc      <= cc_next;
      fault_c <= |csat;
      side_c  <= side_cd[FRW+2*TW-1:2*TW];
      tf_c    <= side_cd[2*TW-1:TW];
      tr_c    <= side_cd[TW-1:0];
      // squares
      for (int k = 0; k < 4; k++) asq[k] <= SW'(alpha[k]) * SW'(alpha[k]);
      tsq_f   <= SW'(tf_c) * SW'(tf_c);
      tsq_r   <= SW'(tr_c) * SW'(tr_c);
      hf_q    <= cc[2];
      hr_q    <= cc[3];
      fault_q <= fault_c;
      side_q  <= side_c;
      // root radicands
      rad[0]  <= asq[0] + tsq_f;
      rad[1]  <= asq[1] + tsq_f;
      rad[2]  <= asq[2] + tsq_r;
      rad[3]  <= asq[3] + tsq_r;
      hf_r    <= hf_q;
      hr_r    <= hr_q;
      fault_r <= fault_q;
      side_r  <= side_q;
    end
  end

  // ---------------- roots ----------------
  logic [H-1:0] root [4];
  for (genvar k = 0; k < 4; k++) begin : g_root
    taso_sqrt #(.SW(SW)) u_sqrt (.clk(clk), .en(adv), .rad(rad[k]), .root(root[k]));
  end

  logic                     v_sd;
  logic [FRW+2*CW:0]        side_sd;
  taso_delay #(.W(FRW + 2 * CW + 1), .DEPTH(H)) u_dly_root (
    .clk(clk), .rst(rst), .en(adv), .vin(v_r), .din({side_r, hf_r, hr_r, fault_r}),
    .vout(v_sd), .dout(side_sd));

  taso_pkg::frame_t     side_s;
  logic signed [CW-1:0] hub_f_s, hub_r_s;
  assign side_s  = side_sd[FRW+2*CW:2*CW+1];
  assign hub_f_s = side_sd[2*CW:CW+1];
  assign hub_r_s = side_sd[CW:1];

  // ---------------- wheel factors ----------------
  logic signed [GW-1:0] gam [4];
  always_comb begin
    gam[0] = $signed({2'b00, root[0]}) - GW'(hub_f_s);
    gam[1] = $signed({2'b00, root[1]}) + GW'(hub_f_s);
    gam[2] = $signed({2'b00, root[2]}) - GW'(hub_r_s);
    gam[3] = $signed({2'b00, root[3]}) + GW'(hub_r_s);
  end

  logic                 v_g;
  logic [GDW-1:0]       gden [4];
  logic signed [QW-1:0] qnum [4];
  logic [3:0]           bad_g;
  logic                 fault_g;
  logic signed [taso_pkg::ANGLE_W-1:0] fa_g, ra_g;
  logic signed [taso_pkg::SPEED_W-1:0] spd [4];

  assign spd[0] = side_s.fl;
  assign spd[1] = side_s.fr;
  assign spd[2] = side_s.rl;
  assign spd[3] = side_s.rr;

  always_ff @(posedge clk) begin
    if (rst) v_g <= 1'b0;
    else if (adv) v_g <= v_sd;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        bad_g[k] <= (gam[k] <= 0);
        gden[k]  <= (gam[k] <= 0) ? GDW'(1) : gam[k][GDW-1:0];
        qnum[k]  <= QW'(spd[k]) <<< (F + 8);
      end
      fault_g <= side_sd[0];
      fa_g    <= side_s.fa;
      ra_g    <= side_s.ra;
    end
  end

  // ---------------- speed quotients ----------------
  logic signed [QW-1:0] quo [4];
  for (genvar k = 0; k < 4; k++) begin : g_quo
    taso_div #(.NW(QW), .DW(GDW)) u_div (
      .clk(clk), .en(adv), .num(qnum[k]), .den(gden[k]), .quo(quo[k]));
  end

  logic                             v_qd;
  logic [2*taso_pkg::ANGLE_W+1:0]   side_qd;
  taso_delay #(.W(2 * taso_pkg::ANGLE_W + 2), .DEPTH(LAT_QUO)) u_dly_quo (
    .clk(clk), .rst(rst), .en(adv), .vin(v_g), .din({fa_g, ra_g, fault_g, |bad_g}),
    .vout(v_qd), .dout(side_qd));

  // ---------------- sum and output ----------------
  logic                   v_s;
  logic signed [SUMW-1:0] sum_q;
  logic [2*taso_pkg::ANGLE_W+1:0] side_o;

  always_ff @(posedge clk) begin
    if (rst) v_s <= 1'b0;
    else if (adv) v_s <= v_qd;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_q  <= SUMW'(quo[0]) + SUMW'(quo[1]) + SUMW'(quo[2]) + SUMW'(quo[3]);
      side_o <= side_qd;
    end
  end

  logic signed [SUMW:0]               rnd;
  logic signed [taso_pkg::SPEED_W-1:0] speed_next;
  logic                               fault_next;
  logic                               zero_out;

  always_comb begin
    rnd        = (($bits(rnd))'(sum_q) + 512) >>> 10;
    zero_out   = len_zero || side_o[0];
    fault_next = side_o[1] || zero_out;
    if (zero_out) begin
      speed_next = '0;
    end else if (rnd > 32767) begin
      speed_next = 16'sh7FFF;
      fault_next = 1'b1;
    end else if (rnd < -32768) begin
      speed_next = -16'sh8000;
      fault_next = 1'b1;
    end else begin
      speed_next = rnd[taso_pkg::SPEED_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else if (adv) result_valid <= v_s;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      longitudinal_speed <= speed_next;
      front_angle_out    <= side_o[2*taso_pkg::ANGLE_W+1:taso_pkg::ANGLE_W+2];
      rear_angle_out     <= side_o[taso_pkg::ANGLE_W+1:2];
      geometry_fault     <= fault_next;
    end
  end

  // ---------------- checks ----------------
  `TASO_ASSERT(a_hold_frozen, clk, rst, !adv |=> $stable(v_s), "pipeline moved during a held result")
  `TASO_ASSERT(a_valid_kept, clk, rst, (!adv && v_p) |=> v_p, "frame lost in stalled pipeline")
  `TASO_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !result_valid, "result valid right after reset")

endmodule

`default_nettype wire

@@ src/taso_delay.sv @@
// ---------------------------------------------------------------------------
// taso_delay
// Shift line that carries a valid bit and side data past a pipelined unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module taso_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         en,
  input  wire logic         vin,
  input  wire logic [W-1:0] din,
  output logic              vout,
  output logic [W-1:0]      dout
);

  logic         vs [0:DEPTH-1];
  logic [W-1:0] ds [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) vs[i] <= 1'b0;
    end else if (en) begin
      vs[0] <= vin;
      for (int i = 1; i < DEPTH; i++) vs[i] <= vs[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ds[0] <= din;
      for (int i = 1; i < DEPTH; i++) ds[i] <= ds[i-1];
    end
  end

  assign vout = vs[DEPTH-1];
  assign dout = ds[DEPTH-1];

endmodule

`default_nettype wire

@@ src/taso_div.sv @@
// ---------------------------------------------------------------------------
// taso_div
// Pipelined restoring divider, one quotient bit per stage, truncating.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module taso_div #(
  parameter int NW = 16,
  parameter int DW = 8
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [NW-1:0] num,
  input  wire logic [DW-1:0]        den,
  output logic signed [NW-1:0]      quo
);

  logic [NW-1:0] qn [0:NW];
  logic [DW-1:0] rm [0:NW];
  logic [DW-1:0] dv [0:NW];
  logic          ng [0:NW];
  logic [NW-1:0] mag;

  assign mag = num[NW-1] ? NW'(-num) : NW'(num);

  always_ff @(posedge clk) begin
    if (en) begin
      qn[0] <= mag;
      rm[0] <= '0;
      dv[0] <= den;
      ng[0] <= num[NW-1];
    end
  end

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;
    assign trial = {rm[i], qn[i][NW-1]};
    assign diff  = trial - {1'b0, dv[i]};
    assign ge    = trial >= {1'b0, dv[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        rm[i+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        qn[i+1] <= {qn[i][NW-2:0], ge};
        dv[i+1] <= dv[i];
        ng[i+1] <= ng[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) quo <= ng[NW] ? -$signed(qn[NW]) : $signed(qn[NW]);
  end

endmodule

`default_nettype wire

@@ src/taso_sqrt.sv @@
// ---------------------------------------------------------------------------
// taso_sqrt
// Pipelined digit-by-digit floor square root, one root bit per stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module taso_sqrt #(
  parameter int SW = 32
) (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic [SW-1:0]   rad,
  output logic [SW/2-1:0]      root
);

  localparam int H  = SW / 2;
  localparam int RW = H + 2;

  logic [SW-1:0] rs [0:H-1];
  logic [RW-1:0] rm [0:H-1];
  logic [H-1:0]  rt [0:H-1];

  for (genvar i = 0; i < H; i++) begin : g_stage
    logic [SW-1:0] r_in;
    logic [RW-1:0] m_in;
    logic [H-1:0]  t_in;
    logic [RW-1:0] trial;
    logic [RW-1:0] tt;
    logic          ge;
    if (i == 0) begin : g_first
      assign r_in = rad;
      assign m_in = '0;
      assign t_in = '0;
    end else begin : g_next
      assign r_in = rs[i-1];
      assign m_in = rm[i-1];
      assign t_in = rt[i-1];
    end
    assign trial = {m_in[RW-3:0], r_in[SW-1:SW-2]};
    assign tt    = {t_in, 2'b01};
    assign ge    = trial >= tt;
    always_ff @(posedge clk) begin
      if (en) begin
        rs[i] <= r_in << 2;
        rm[i] <= ge ? trial - tt : trial;
        rt[i] <= {t_in[H-2:0], ge};
      end
    end
  end

  assign root = rt[H-1];

endmodule

`default_nettype wire

@@ src/taso_tan.sv @@
// ---------------------------------------------------------------------------
// taso_tan
// Pipelined CORDIC rotation followed by a y/x divider: angle to tangent.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module taso_tan #(
  parameter int FRAC_BITS  = 14,
  parameter int ITERATIONS = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  en,
  input  wire logic signed [taso_pkg::ANGLE_W-1:0]   angle,
  output logic signed [FRAC_BITS+4:0]                tan_q
);

  localparam int XW  = FRAC_BITS + 3;
  localparam int ZW  = FRAC_BITS + 17;
  localparam int NW  = XW + FRAC_BITS;
  localparam int TW  = FRAC_BITS + 5;
  localparam int SHL = (FRAC_BITS >= 14) ? FRAC_BITS - 14 : 0;
  localparam int SHR = (FRAC_BITS < 14) ? 14 - FRAC_BITS : 0;
  localparam logic signed [XW-1:0] ONE = {{(XW-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic signed [XW-1:0] X_MIN = {{(XW-1){1'b0}}, 1'b1};

  logic signed [taso_pkg::ANGLE_W-1:0] a_c;
  logic signed [ZW-1:0]                a_z;
  logic signed [XW-1:0]                xs [0:ITERATIONS];
  logic signed [XW-1:0]                ys [0:ITERATIONS];
  logic signed [ZW-1:0]                zs [0:ITERATIONS];
  logic signed [XW-1:0]                xc;
  logic signed [NW-1:0]                num;
  logic signed [NW-1:0]                quo;

  // clamp for the tangent only
  always_comb begin
    if (angle > taso_pkg::ANGLE_LIMIT) a_c = taso_pkg::ANGLE_LIMIT;
    else if (angle < -taso_pkg::ANGLE_LIMIT) a_c = -taso_pkg::ANGLE_LIMIT;
    else a_c = angle;
    a_z = (ZW'(a_c) <<< SHL) >>> SHR;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= ONE;
      ys[0] <= '0;
      zs[0] <= a_z;
    end
  end

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_rot
    localparam logic signed [ZW-1:0] STEP = ZW'(taso_pkg::ATAN_Q30[i] >> (30 - FRAC_BITS));
    always_ff @(posedge clk) begin
      if (en) begin
        if (zs[i] >= 0) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - STEP;
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + STEP;
        end
      end
    end
  end

  assign xc  = (xs[ITERATIONS] <= 0) ? X_MIN : xs[ITERATIONS];
  assign num = NW'(ys[ITERATIONS]) <<< FRAC_BITS;

  taso_div #(.NW(NW), .DW(XW - 1)) u_div (
    .clk (clk),
    .en  (en),
    .num (num),
    .den (xc[XW-2:0]),
    .quo (quo)
  );

  assign tan_q = quo[TW-1:0];

endmodule

`default_nettype wire

@@ tb/two_axle_steering_odometry_tb.sv @@
// ---------------------------------------------------------------------------
// two_axle_steering_odometry_tb
// Self-checking bench: drives odometry frames under random gaps and output
// stalls, predicts every result in fixed point and compares it field by
// field, across several geometry register settings.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_axle_steering_odometry_tb;

  localparam int FRAC   = 14;
  localparam int ITERS  = 16;
  localparam longint ONE_Q    = longint'(1) << FRAC;
  localparam longint TERM_MAX = longint'(64) << FRAC;

  typedef struct packed {
    logic signed [taso_pkg::SPEED_W-1:0] speed;
    logic signed [taso_pkg::ANGLE_W-1:0] fa;
    logic signed [taso_pkg::ANGLE_W-1:0] ra;
    logic                                fault;
  } odo_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [taso_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [taso_pkg::CFG_W-1:0] cfg_data = '0;
  logic frame_valid = 1'b0;
  logic frame_stall;
  taso_pkg::frame_t frm = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic signed [taso_pkg::SPEED_W-1:0] longitudinal_speed;
  logic signed [taso_pkg::ANGLE_W-1:0] front_angle_out, rear_angle_out;
  logic geometry_fault;

  // geometry as the block holds it
  logic [taso_pkg::LEN_W-1:0] wb_front = 13'd1000, wb_rear = 13'd1000;
  logic [taso_pkg::LEN_W-1:0] trk_front = 13'd1000, trk_rear = 13'd1000;
  logic [taso_pkg::HUB_W-1:0] hub_front = '0, hub_rear = '0;

  odo_t pending_odo[$];
  int   errors = 0;
  bit   idling = 1'b1;
  int   rx_hold = 0;

  two_axle_steering_odometry i_dut (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .frame_valid, .frame_stall,
    .front_left_speed(frm.fl), .front_right_speed(frm.fr),
    .rear_left_speed(frm.rl), .rear_right_speed(frm.rr),
    .front_angle(frm.fa), .rear_angle(frm.ra),
    .result_valid, .result_stall,
    .longitudinal_speed, .front_angle_out, .rear_angle_out, .geometry_fault
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("two_axle_steering_odometry test failed");
    $finish;
  end

  // ---- predictor ----
  function automatic longint axle_tan(logic signed [taso_pkg::ANGLE_W-1:0] ang);
    longint a, z, x, y, nx, step;
    a = longint'(ang);
    if (a > taso_pkg::ANGLE_LIMIT) a = taso_pkg::ANGLE_LIMIT;
    if (a < -taso_pkg::ANGLE_LIMIT) a = -taso_pkg::ANGLE_LIMIT;
    z = a <<< (FRAC - 14);
    x = ONE_Q;
    y = 0;
    for (int i = 0; i < ITERS; i++) begin
      step = longint'(taso_pkg::ATAN_Q30[i] >> (30 - FRAC));
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= step;
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += step;
      end
      x = nx;
    end
    if (x <= 0) x = 1;
    return (y * ONE_Q) / x;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned s);
    longint unsigned r, nr;
    int b;
    if (s == 0) return 0;
    b = 0;
    while (b < 64 && (s >> b) != 0) b++;
    r = longint'(1) << ((b + 1) / 2);
    for (int i = 0; i < ITERS; i++) begin
      nr = (r + s / r) >> 1;
      if (nr < r) r = nr;
    end
    return r;
  endfunction

  function automatic longint clamp_term(longint v, inout logic flt);
    if (v > TERM_MAX) begin
      flt = 1'b1;
      return TERM_MAX;
    end
    if (v < -TERM_MAX) begin
      flt = 1'b1;
      return -TERM_MAX;
    end
    return v;
  endfunction

  function automatic longint wheel_gamma(longint half, longint hub, longint t, longint side);
    longint alpha;
    longint unsigned s;
    alpha = ONE_Q + side * half;
    s = longint'(alpha * alpha) + longint'(t * t);
    return longint'(floor_root(s)) + side * hub;
  endfunction

  function automatic odo_t predict_odometry(taso_pkg::frame_t f);
    odo_t o;
    longint tf, tr, len, d, fh, rh, fo, ro, acc, spd;
    longint g[4];
    longint sp[4];
    logic flt, bad;
    flt = 1'b0;
    bad = 1'b0;
    spd = 0;
    sp[0] = longint'(f.fl);
    sp[1] = longint'(f.fr);
    sp[2] = longint'(f.rl);
    sp[3] = longint'(f.rr);
    tf = axle_tan(f.fa);
    tr = axle_tan(f.ra);
    len = longint'(wb_front) + longint'(wb_rear);
    if (len == 0) begin
      flt = 1'b1;
      bad = 1'b1;
    end else begin
      d = tf - tr;
      fh = clamp_term((d * longint'(trk_front)) / (2 * len), flt);
      rh = clamp_term((d * longint'(trk_rear)) / (2 * len), flt);
      fo = clamp_term((d * longint'(hub_front)) / len, flt);
      ro = clamp_term((d * longint'(hub_rear)) / len, flt);
      g[0] = wheel_gamma(fh, fo, tf, -1);
      g[1] = wheel_gamma(fh, fo, tf, 1);
      g[2] = wheel_gamma(rh, ro, tr, -1);
      g[3] = wheel_gamma(rh, ro, tr, 1);
      acc = 0;
      for (int k = 0; k < 4; k++) begin
        if (g[k] <= 0) begin
          flt = 1'b1;
          bad = 1'b1;
        end else begin
          acc += (sp[k] * (longint'(1) << (FRAC + 8))) / g[k];
        end
      end
      if (!bad) begin
        spd = (acc + 512) >>> 10;
        if (spd > 32767) begin
          spd = 32767;
          flt = 1'b1;
        end
        if (spd < -32768) begin
          spd = -32768;
          flt = 1'b1;
        end
      end
    end
    if (bad) spd = 0;
    o.speed = spd[15:0];
    o.fa = f.fa;
    o.ra = f.ra;
    o.fault = flt;
    return o;
  endfunction

  // ---- result checking ----
  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    odo_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_odo.size() == 0) begin
        $display("%0t: result transfer with nothing expected", $realtime);
        errors++;
      end else begin
        want = pending_odo.pop_front();
        if (longitudinal_speed !== want.speed)
          report_mismatch("longitudinal_speed", longint'(longitudinal_speed),
                          longint'(want.speed));
        if (front_angle_out !== want.fa)
          report_mismatch("front_angle_out", longint'(front_angle_out), longint'(want.fa));
        if (rear_angle_out !== want.ra)
          report_mismatch("rear_angle_out", longint'(rear_angle_out), longint'(want.ra));
        if (geometry_fault !== want.fault)
          report_mismatch("geometry_fault", longint'(geometry_fault), longint'(want.fault));
      end
    end
  end

  // output stall: random while idling, off otherwise, or held for a counted stretch
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      result_stall <= 1'b1;
      rx_hold <= rx_hold - 1;
    end else if (!idling) begin
      result_stall <= 1'b0;
    end else begin
      int r;
      r = $urandom_range(99);
      result_stall <= (r < 20) || (r < 22 && result_stall);
    end
  end

  // ---- stimulus ----
  function automatic int pick_gap();
    int r;
    if (!idling) return 0;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_frame(taso_pkg::frame_t f, int gap);
    frm = f;
    frame_valid = 1'b1;
    do @(posedge clk); while (frame_stall);
    pending_odo.push_back(predict_odometry(f));
    @(negedge clk);
    if (gap > 0) begin
      frame_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic write_geometry(taso_pkg::cfg_reg_t idx, int val);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = val[taso_pkg::CFG_W-1:0];
    @(negedge clk);
    cfg_write = 1'b0;
    case (idx)
      taso_pkg::CFG_FRONT_WHEELBASE: wb_front = val[taso_pkg::LEN_W-1:0];
      taso_pkg::CFG_REAR_WHEELBASE:  wb_rear = val[taso_pkg::LEN_W-1:0];
      taso_pkg::CFG_FRONT_TRACK:     trk_front = val[taso_pkg::LEN_W-1:0];
      taso_pkg::CFG_REAR_TRACK:      trk_rear = val[taso_pkg::LEN_W-1:0];
      taso_pkg::CFG_FRONT_HUB:       hub_front = val[taso_pkg::HUB_W-1:0];
      taso_pkg::CFG_REAR_HUB:        hub_rear = val[taso_pkg::HUB_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(int wf, int wr, int tf, int tr, int hf, int hr);
    write_geometry(taso_pkg::CFG_FRONT_WHEELBASE, wf);
    write_geometry(taso_pkg::CFG_REAR_WHEELBASE, wr);
    write_geometry(taso_pkg::CFG_FRONT_TRACK, tf);
    write_geometry(taso_pkg::CFG_REAR_TRACK, tr);
    write_geometry(taso_pkg::CFG_FRONT_HUB, hf);
    write_geometry(taso_pkg::CFG_REAR_HUB, hr);
  endtask

  task automatic drain();
    frame_valid = 1'b0;
    while (pending_odo.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  function automatic logic signed [taso_pkg::ANGLE_W-1:0] rand_angle();
    int r;
    r = $urandom_range(99);
    if (r < 80) return taso_pkg::ANGLE_W'(int'($urandom_range(0, 2 * 22938)) - 22938);
    if (r < 85) return $urandom_range(0, 1) ? taso_pkg::ANGLE_LIMIT : -taso_pkg::ANGLE_LIMIT;
    if (r < 90) return '0;
    return taso_pkg::ANGLE_W'($urandom());
  endfunction

  function automatic taso_pkg::frame_t rand_frame();
    taso_pkg::frame_t f;
    f.fl = taso_pkg::SPEED_W'($urandom());
    f.fr = taso_pkg::SPEED_W'($urandom());
    f.rl = taso_pkg::SPEED_W'($urandom());
    f.rr = taso_pkg::SPEED_W'($urandom());
    if ($urandom_range(3) == 0) begin
      // similar wheel speeds, as on a real base
      f.fr = f.fl + $signed(16'($urandom_range(0, 200))) - 16'sd100;
      f.rl = f.fl;
      f.rr = f.fr;
    end
    f.fa = rand_angle();
    f.ra = rand_angle();
    return f;
  endfunction

  task automatic send_random(int n);
    repeat (n) send_frame(rand_frame(), pick_gap());
  endtask

  task automatic test_directed();
    taso_pkg::frame_t f;
    logic signed [15:0] sv[5] = '{16'sh7FFF, -16'sh8000, 16'sd0, 16'sd1, -16'sd1};
    logic signed [15:0] av[7] = '{16'sd0, 16'sd22938, -16'sd22938, 16'sh7FFF,
                                  -16'sh8000, 16'sd22939, 16'sd8192};
    for (int i = 0; i < 5; i++) begin
      f.fl = sv[i]; f.fr = sv[i]; f.rl = sv[i]; f.rr = sv[i];
      f.fa = av[i]; f.ra = av[6 - i];
      send_frame(f, pick_gap());
    end
    for (int i = 0; i < 7; i++) begin
      f.fl = 16'sh7FFF; f.fr = -16'sh8000; f.rl = 16'sd12345; f.rr = -16'sd321;
      f.fa = av[i]; f.ra = -av[i];
      send_frame(f, pick_gap());
    end
    drain();
  endtask

  // fixed settings at and near the register extremes
  task automatic test_extreme_geometry();
    set_geometry(0, 0, 1000, 1000, 0, 0);           // no wheelbase at all
    send_random(20);
    drain();
    set_geometry(8191, 8191, 8191, 8191, 2047, 2047);
    send_random(60);
    drain();
    set_geometry(1, 0, 8191, 8191, 2047, 2047);     // terms saturate
    send_random(60);
    drain();
    set_geometry(200, 100, 8191, 0, 2047, 0);       // factors can go non-positive
    send_random(60);
    drain();
    set_geometry(8191, 0, 0, 0, 0, 0);
    send_random(40);
    drain();
  endtask

  task automatic test_random_geometry();
    for (int p = 0; p < 10; p++) begin
      idling = (p % 3) != 2;
      set_geometry($urandom_range(1, 8191), $urandom_range(0, 8191),
                   $urandom_range(0, 8191), $urandom_range(0, 8191),
                   $urandom_range(0, 2047), $urandom_range(0, 2047));
      send_random(120);
      drain();
    end
    idling = 1'b1;
  endtask

  // long output hold while frames keep coming, so the input stalls
  task automatic test_backpressure();
    set_geometry(1000, 1200, 1500, 1400, 100, 50);
    idling = 1'b0;
    rx_hold = 400;
    send_random(300);
    idling = 1'b1;
    drain();
  endtask

  task automatic test_sender_pause();
    set_geometry(1000, 1000, 1000, 1000, 0, 0);     // back to reset values
    send_random(80);
    drain();                                        // everything out before more
    send_random(80);
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_extreme_geometry();
    test_random_geometry();
    test_backpressure();
    test_sender_pause();
    drain();
    repeat (200) @(posedge clk);
    if (errors == 0 && pending_odo.size() == 0) begin
      $display("two_axle_steering_odometry test passed");
    end else begin
      $display("two_axle_steering_odometry test failed");
    end
    $finish;
  end

endmodule

@@ two_axle_steering_odometry.f @@
+incdir+src
src/taso_pkg.sv
src/taso_delay.sv
src/taso_div.sv
src/taso_sqrt.sv
src/taso_tan.sv
src/two_axle_steering_odometry.sv
tb/two_axle_steering_odometry_tb.sv
